// ===== design/msbl_pkg.sv =====
// Shared types and constants for the mean/stddev band-limit block.
// No dependencies; imported by every module of the block.
package msbl_pkg;

  localparam int SAMPLE_W = 24;  // Q8.16 input sample
  localparam int LEVEL_W  = 32;  // Q16.16 band limit
  localparam int FACTOR_W = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 24'sh7FFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_DEVIATION_FACTOR = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_NS,
    ST_MUL_NS,
    ST_LOAD_SS,
    ST_MUL_SS,
    ST_LOAD_RT,
    ST_SQRT,
    ST_SPAN,
    ST_LOAD_LO,
    ST_DIV_LO,
    ST_LOAD_HI,
    ST_DIV_HI,
    ST_FINISH
  } msbl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD_NS,
    CMD_STEP_NS,
    CMD_LOAD_SS,
    CMD_STEP_SS,
    CMD_LOAD_RT,
    CMD_STEP_RT,
    CMD_SPAN,
    CMD_LOAD_LO,
    CMD_STEP_DIV,
    CMD_LOAD_HI,
    CMD_FINISH
  } msbl_op_e;

  typedef struct packed {
    logic     take;  // sample transaction this cycle
    msbl_op_e op;
  } msbl_cmd_t;

endpackage

// ===== design/mean_stddev_band_limits.sv =====
// After a last sample the block computes (multiply, square root, divide) before
// m_axis_tvalid; s_axis_tready is low meanwhile.
// Throughput: one sample per cycle within a run; the tail is set by the bit-serial
// multiplier, the one-bit-per-cycle square root and two restoring divisions.
// Reset: rst_ni async low clears run state (smallest = max sample) and sets factor to 1.
// Depends on msbl_pkg, msbl_ctrl, msbl_datapath.
module mean_stddev_band_limits #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample
  input  logic        s_axis_tlast,   // last sample of the run
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] min_value, [63:32] max_value
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msbl_pkg::APB_AW-1:0]   paddr,
  input  logic [msbl_pkg::APB_DW-1:0]   pwdata,
  output logic [msbl_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import msbl_pkg::*;

  // Widths sized for the longest run: count, sum, square sum, n*S2 - S1^2,
  // its root, factor*root, and the signed numerators with headroom.
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int D_W    = CNT_W + SQ_W;
  localparam int RT_W   = (D_W + 1) / 2;
  localparam int SPAN_W = RT_W + FACTOR_W;
  localparam int NUM_W  = ((SUM_W > SPAN_W) ? SUM_W : SPAN_W) + 2;
  localparam int STEP_W = $clog2(NUM_W);

  logic [FACTOR_W-1:0] factor_q, factor_d;
  logic                cfg_wr;
  msbl_cmd_t           cmd;
  logic signed [LEVEL_W-1:0] min_value, max_value;

  // APB: no wait states; writes land on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    factor_d = factor_q;
    if (cfg_wr && paddr[2] == REG_DEVIATION_FACTOR) factor_d = pwdata[FACTOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else begin
      factor_q <= factor_d;
    end
  end

  // unmapped addresses read as zero
  assign prdata = (paddr[2] == REG_DEVIATION_FACTOR) ? APB_DW'(factor_q) : '0;

  msbl_ctrl #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W),
    .RT_W  (RT_W),
    .NUM_W (NUM_W),
    .STEP_W(STEP_W)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_last_i (s_axis_tlast),
    .s_ready_o(s_axis_tready),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .cmd_o    (cmd)
  );

  msbl_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .SQ_W       (SQ_W),
    .D_W        (D_W),
    .RT_W       (RT_W),
    .SPAN_W     (SPAN_W),
    .NUM_W      (NUM_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sample_i   ($signed(s_axis_tdata)),
    .factor_i   (factor_q),
    .min_value_o(min_value),
    .max_value_o(max_value)
  );

  // output register lives in the datapath; valid is held by the controller
  assign m_axis_tdata = {max_value, min_value};

endmodule

// ===== design/msbl_ctrl.sv =====
// Sequencer for the band-limit block: accumulate, multiply, sqrt, divide.
// Depends on msbl_pkg; drives msbl_datapath through msbl_cmd_t.
module msbl_ctrl #(
  parameter int CNT_W  = 11,
  parameter int SUM_W  = 35,
  parameter int RT_W   = 34,
  parameter int NUM_W  = 44,
  parameter int STEP_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_last_i,
  output logic              s_ready_o,
  input  logic              m_ready_i,
  output logic              m_valid_o,
  output msbl_pkg::msbl_cmd_t cmd_o
);
  import msbl_pkg::*;

  msbl_state_e        state_q, state_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !m_ready_i;
    s_ready_o   = 1'b0;
    cmd_o.take  = 1'b0;
    cmd_o.op    = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.take = s_valid_i;
        if (s_valid_i && s_last_i) state_d = ST_LOAD_NS;
      end
      ST_LOAD_NS: begin
        cmd_o.op = CMD_LOAD_NS;
        cnt_d    = STEP_W'(CNT_W - 1);
        state_d  = ST_MUL_NS;
      end
      ST_MUL_NS: begin
        cmd_o.op = CMD_STEP_NS;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_LOAD_SS;
      end
      ST_LOAD_SS: begin
        cmd_o.op = CMD_LOAD_SS;
        cnt_d    = STEP_W'(SUM_W - 1);
        state_d  = ST_MUL_SS;
      end
      ST_MUL_SS: begin
        cmd_o.op = CMD_STEP_SS;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_LOAD_RT;
      end
      ST_LOAD_RT: begin
        cmd_o.op = CMD_LOAD_RT;
        cnt_d    = STEP_W'(RT_W - 1);
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = CMD_STEP_RT;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_SPAN;
      end
      ST_SPAN: begin
        cmd_o.op = CMD_SPAN;
        state_d  = ST_LOAD_LO;
      end
      ST_LOAD_LO: begin
        cmd_o.op = CMD_LOAD_LO;
        cnt_d    = STEP_W'(NUM_W - 1);
        state_d  = ST_DIV_LO;
      end
      ST_DIV_LO: begin
        cmd_o.op = CMD_STEP_DIV;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_LOAD_HI;
      end
      ST_LOAD_HI: begin
        cmd_o.op = CMD_LOAD_HI;
        cnt_d    = STEP_W'(NUM_W - 1);
        state_d  = ST_DIV_HI;
      end
      ST_DIV_HI: begin
        cmd_o.op = CMD_STEP_DIV;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.op    = CMD_FINISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_valid_o = out_valid_q;

  // a last sample always starts the computation
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o && s_last_i) |=> (state_q == ST_LOAD_NS))
    else $error("last sample did not start computation");

  // finishing always presents a result
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && (!out_valid_q || m_ready_i)) |=> out_valid_q)
    else $error("finished result not presented");

  // sqrt iteration count stays within the root width
  a_sqrt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (cnt_q < STEP_W'(RT_W)))
    else $error("sqrt step counter out of range");

endmodule

// ===== design/msbl_datapath.sv =====
// Datapath: run accumulators, shift-add multiplier, digit sqrt, divider.
// Depends on msbl_pkg; sequenced by msbl_ctrl through msbl_cmd_t.
module msbl_datapath #(
  parameter int MAX_SAMPLES = 1024,
  parameter int CNT_W  = 11,
  parameter int SUM_W  = 35,
  parameter int SQ_W   = 57,
  parameter int D_W    = 68,
  parameter int RT_W   = 34,
  parameter int SPAN_W = 42,
  parameter int NUM_W  = 44
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  msbl_pkg::msbl_cmd_t                     cmd_i,
  input  logic signed [msbl_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic [msbl_pkg::FACTOR_W-1:0]           factor_i,
  output logic signed [msbl_pkg::LEVEL_W-1:0]     min_value_o,
  output logic signed [msbl_pkg::LEVEL_W-1:0]     max_value_o
);
  import msbl_pkg::*;

  localparam int DP_W = 2 * RT_W;
  localparam logic signed [NUM_W-1:0] LVL_HI = NUM_W'(64'sd2147483647);
  localparam logic signed [NUM_W-1:0] LVL_LO = NUM_W'(-64'sd2147483648);

  function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] c;
    c = v;
    if (v > LVL_HI) c = LVL_HI;
    if (v < LVL_LO) c = LVL_LO;
    return $signed(c[LEVEL_W-1:0]);
  endfunction

  // run state
  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic signed [SAMPLE_W-1:0] small_q, small_d;

  // compute registers
  logic [D_W-1:0]            acc_q, acc_d;
  logic [D_W-1:0]            mcand_q, mcand_d;
  logic [SUM_W-1:0]          mplier_q, mplier_d;
  logic [DP_W-1:0]           rad_q, rad_d;
  logic [RT_W:0]             rem_q, rem_d;
  logic [RT_W-1:0]           root_q, root_d;
  logic [SPAN_W-1:0]         span_q, span_d;
  logic [NUM_W-1:0]          dvd_q, dvd_d;
  logic                      neg_q, neg_d;
  logic [CNT_W-1:0]          drem_q, drem_d;
  logic signed [LEVEL_W-1:0] lo_q, lo_d;
  logic signed [LEVEL_W-1:0] min_q, min_d, max_q, max_d;

  logic [SAMPLE_W-1:0]       mag;
  logic [2*SAMPLE_W-1:0]     mag_sq;
  logic [SUM_W-1:0]          sum_mag;
  logic [RT_W+2:0]           rem_sh, trial;
  logic [CNT_W:0]            div_sh, div_n;
  logic signed [NUM_W-1:0]   sum_ext, span_ext, num_lo, num_hi, quot, small_ext, lo_pick;

  always_comb begin
    mag     = sample_i[SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
    mag_sq  = mag * mag;
    sum_mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
    rem_sh  = {rem_q, rad_q[DP_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    div_sh  = {drem_q, dvd_q[NUM_W-1]};
    div_n   = {1'b0, count_q};
    sum_ext   = NUM_W'(sum_q);
    span_ext  = $signed(NUM_W'(span_q));
    num_lo    = sum_ext - span_ext;
    num_hi    = sum_ext + span_ext;
    quot      = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
    small_ext = NUM_W'(small_q);
    lo_pick   = (quot < small_ext) ? small_ext : quot;
  end

  always_comb begin
    count_d  = count_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    small_d  = small_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rad_d    = rad_q;
    rem_d    = rem_q;
    root_d   = root_q;
    span_d   = span_q;
    dvd_d    = dvd_q;
    neg_d    = neg_q;
    drem_d   = drem_q;
    lo_d     = lo_q;
    min_d    = min_q;
    max_d    = max_q;

    // samples past the run limit are dropped
    if (cmd_i.take && (count_q < CNT_W'(MAX_SAMPLES))) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + SUM_W'(sample_i);
      sq_d    = sq_q + SQ_W'(mag_sq);
      if (sample_i < small_q) small_d = sample_i;
    end

    case (cmd_i.op)
      CMD_LOAD_NS: begin
        acc_d    = '0;
        mcand_d  = D_W'(sq_q);
        mplier_d = SUM_W'(count_q);
      end
      CMD_STEP_NS: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
      CMD_LOAD_SS: begin
        mcand_d  = D_W'(sum_mag);
        mplier_d = sum_mag;
      end
      CMD_STEP_SS: begin
        if (mplier_q[0]) acc_d = acc_q - mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
      CMD_LOAD_RT: begin
        rad_d  = DP_W'(acc_q);
        rem_d  = '0;
        root_d = '0;
      end
      CMD_STEP_RT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = (RT_W+1)'(rem_sh - trial);
          root_d = RT_W'({root_q, 1'b1});
        end else begin
          rem_d  = (RT_W+1)'(rem_sh);
          root_d = RT_W'({root_q, 1'b0});
        end
      end
      CMD_SPAN: begin
        span_d = SPAN_W'(factor_i) * SPAN_W'(root_q);
      end
      CMD_LOAD_LO: begin
        dvd_d  = num_lo[NUM_W-1] ? NUM_W'(-num_lo) : NUM_W'(num_lo);
        neg_d  = num_lo[NUM_W-1];
        drem_d = '0;
      end
      CMD_STEP_DIV: begin
        if (div_sh >= div_n) begin
          drem_d = CNT_W'(div_sh - div_n);
          dvd_d  = {dvd_q[NUM_W-2:0], 1'b1};
        end else begin
          drem_d = CNT_W'(div_sh);
          dvd_d  = {dvd_q[NUM_W-2:0], 1'b0};
        end
      end
      CMD_LOAD_HI: begin
        lo_d   = sat_level(lo_pick);
        dvd_d  = num_hi[NUM_W-1] ? NUM_W'(-num_hi) : NUM_W'(num_hi);
        neg_d  = num_hi[NUM_W-1];
        drem_d = '0;
      end
      CMD_FINISH: begin
        min_d   = lo_q;
        max_d   = sat_level(quot);
        count_d = '0;
        sum_d   = '0;
        sq_d    = '0;
        small_d = SAMPLE_TOP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      small_q <= SAMPLE_TOP;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      small_q <= small_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rad_q    <= rad_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    span_q   <= span_d;
    dvd_q    <= dvd_d;
    neg_q    <= neg_d;
    drem_q   <= drem_d;
    lo_q     <= lo_d;
    min_q    <= min_d;
    max_q    <= max_d;
  end

  assign min_value_o = min_q;
  assign max_value_o = max_q;

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count past run limit");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_FINISH) |=> (count_q == '0 && sum_q == '0 && small_q == SAMPLE_TOP))
    else $error("run state not cleared after result");

  a_full_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && count_q == CNT_W'(MAX_SAMPLES)) |=> ($stable(sum_q) && $stable(sq_q)))
    else $error("sample accumulated past run limit");

endmodule

// ===== tb/sv/band_limits_checker.sv =====
// Scoreboard for mean_stddev_band_limits: watches the sample, result and register
// channels, predicts every band from its own copy of the run state, compares results.
// Depends on msbl_pkg.
module band_limits_checker #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [23:0]                 s_tdata_i,   // [23:0] sample
  input  logic                        s_tlast_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [63:0]                 m_tdata_i,   // [31:0] min_value, [63:32] max_value
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [msbl_pkg::APB_AW-1:0] paddr_i,
  input  logic [msbl_pkg::APB_DW-1:0] pwdata_i,
  input  logic [msbl_pkg::APB_DW-1:0] prdata_i,
  input  logic                        pready_i,
  output int                          mismatch_count_o,
  output int                          pending_count_o,
  output int                          checked_count_o
);
  import msbl_pkg::*;

  typedef struct {
    logic signed [LEVEL_W-1:0] lower;
    logic signed [LEVEL_W-1:0] upper;
  } band_t;

  band_t band_q[$];

  int unsigned               run_count;
  longint                    run_sum;
  logic [63:0]               run_sq_sum;
  logic signed [SAMPLE_W-1:0] run_min;
  logic [FACTOR_W-1:0]       dev_factor;

  function automatic void clear_run();
    run_count  = 0;
    run_sum    = 0;
    run_sq_sum = '0;
    run_min    = SAMPLE_TOP;
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] d);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= d) root = cand;
    end
    return root;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[LEVEL_W-1:0];
  endfunction

  // n*S2 - S1^2 is exact; its floor root over n is the population deviation
  function automatic band_t band_of_run();
    band_t        res;
    longint       n;
    longint       span;
    longint       lo;
    longint       hi;
    logic [63:0]  mag;
    logic [63:0]  root;
    logic [127:0] dev;
    logic [127:0] sq;
    n    = (run_count != 0) ? longint'(run_count) : 64'sd1;
    mag  = (run_sum < 0) ? -run_sum : run_sum;
    dev  = 128'(n) * 128'(run_sq_sum);
    sq   = 128'(mag) * 128'(mag);
    dev  = (sq <= dev) ? dev - sq : '0;
    root = isqrt(dev);
    span = longint'(dev_factor) * longint'(root);
    lo   = (run_sum - span) / n;
    hi   = (run_sum + span) / n;
    if (lo < longint'(run_min)) lo = longint'(run_min);
    res.lower = sat32(lo);
    res.upper = sat32(hi);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    if (mismatch_count_o < 10)
      $display("mismatch @%0t: %s expected %0d got %0d", $time, what, want, got);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [LEVEL_W-1:0]  got_lo;
    logic signed [LEVEL_W-1:0]  got_hi;
    band_t                      want;
    if (!rst_ni) begin
      clear_run();
      dev_factor = FACTOR_RESET;
      band_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      checked_count_o  = 0;
    end else begin
      // register transaction
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_DEVIATION_FACTOR) begin
        if (pwrite_i) begin
          dev_factor = pwdata_i[FACTOR_W-1:0];
        end else if (prdata_i != APB_DW'(dev_factor)) begin
          flag_mismatch("deviation_factor readback", dev_factor, prdata_i);
        end
      end
      // sample transaction; past the sample limit only the last mark counts
      if (s_tvalid_i && s_tready_i) begin
        smp = s_tdata_i[SAMPLE_W-1:0];
        if (run_count < MAX_SAMPLES) begin
          run_count++;
          run_sum    += longint'(smp);
          run_sq_sum += 64'(longint'(smp) * longint'(smp));
          if (smp < run_min) run_min = smp;
        end
        if (s_tlast_i) begin
          band_q.push_back(band_of_run());
          clear_run();
        end
      end
      // result transaction
      if (m_tvalid_i && m_tready_i) begin
        got_lo = m_tdata_i[31:0];
        got_hi = m_tdata_i[63:32];
        if (band_q.size() == 0) begin
          flag_mismatch("result with no band pending, min_value", 0, got_lo);
        end else begin
          want = band_q.pop_front();
          checked_count_o++;
          if (got_lo != want.lower) flag_mismatch("min_value", want.lower, got_lo);
          if (got_hi != want.upper) flag_mismatch("max_value", want.upper, got_hi);
        end
      end
      pending_count_o = band_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the band-limit testbench: clock, reset, sample/register stimulus, watchdog
// and verdict. Depends on msbl_pkg, mean_stddev_band_limits and band_limits_checker.
module testbench;
  import msbl_pkg::*;

  localparam int MAX_SAMPLES    = 1024;
  localparam int COMPUTE_CYCLES = 200;   // covers the compute tail after a last sample
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction
  localparam int PHASE_ITEMS    = 125;

  localparam logic [APB_AW-1:0] ADDR_FACTOR = {REG_DEVIATION_FACTOR, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;  // index one past the register list

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 24'sh800000;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // [23:0] sample
  logic              s_axis_tlast;   // last sample of the run
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [63:0]       m_axis_tdata;   // [31:0] min_value, [63:32] max_value
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int errors;
  int pending;
  int checked;

  // handshake pressure, changed between phases
  int idle_pct;
  int stall_pct;

  int sample_total;
  int run_total;
  int idle_cycles;

  mean_stddev_band_limits #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  band_limits_checker #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .mismatch_count_o(errors),
    .pending_count_o (pending),
    .checked_count_o (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: one tready decision per falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d bands pending",
               idle_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One sample transaction. tvalid stays high into the next call, so back-to-back
  // samples see no bubble unless the idle draw asks for one.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sample_total++;
    if (last) run_total++;
  endtask

  // Mostly full-range values, with extremes and near-zero values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_TOP;
      1:       return SAMPLE_BOTTOM;
      2, 3:    return SAMPLE_W'($signed($urandom_range(2000)) - 1000);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1);
  endtask

  // Sender pause until every predicted band has come back.
  task automatic wait_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Idle point for register access: results drained and the compute tail over.
  task automatic wait_quiet();
    wait_results();
    repeat (COMPUTE_CYCLES) @(negedge clk_i);
  endtask

  // Setup cycle, then access cycle until pready.
  task automatic apb_access(input logic [APB_AW-1:0] addr, input logic wr,
                            input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_factor(input logic [FACTOR_W-1:0] factor);
    wait_quiet();
    apb_access(ADDR_FACTOR, 1'b1, APB_DW'(factor));
    apb_access(ADDR_FACTOR, 1'b0, '0);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int phase_items;
    int len;
    idle_tab  = '{0, 56, 0, 6};
    stall_tab = '{0, 0, 56, 6};

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    sample_total  = 0;
    run_total     = 0;
    idle_cycles   = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part, reset factor of 1 ----
    apb_access(ADDR_FACTOR, 1'b0, '0);          // reset value readback
    send_sample(24'sd0, 1'b1);                  // single sample: both limits equal it
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(SAMPLE_BOTTOM, 1'b1);
    send_sample(SAMPLE_BOTTOM, 1'b0);           // widest possible spread
    send_sample(SAMPLE_TOP, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sh123456, 1'b0);
    send_sample(-24'sh654321, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(24'sd5, 1'b1);

    // largest factor on extreme alternation: lower limit clamps at the minimum
    set_factor(8'd255);
    send_sample(SAMPLE_BOTTOM, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_BOTTOM, 1'b0);
    send_sample(SAMPLE_TOP, 1'b1);

    // factor of zero: both limits at the truncated mean
    set_factor(8'd0);
    send_sample(24'sd100, 1'b0);
    send_sample(-24'sd200, 1'b0);
    send_sample(24'sd300, 1'b1);

    // write past the register list must leave the factor alone
    wait_quiet();
    apb_access(ADDR_UNUSED, 1'b1, APB_DW'(8'd77));
    apb_access(ADDR_FACTOR, 1'b0, '0);

    // ---- run too long: the samples past the limit must not count ----
    set_factor(8'd3);
    for (int k = 0; k < MAX_SAMPLES; k++)
      send_sample(SAMPLE_W'($urandom_range(8388607)), 1'b0);
    for (int k = 0; k < 6; k++) send_sample(SAMPLE_BOTTOM, k == 5);

    // ---- random phases: no idling, sender idle, receiver stall, both ----
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_factor(8'd0);
        1:       set_factor(8'd255);
        default: set_factor(FACTOR_W'($urandom_range(255)));
      endcase
      idle_pct    = idle_tab[ph];
      stall_pct   = stall_tab[ph];
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(10, 1);
        send_run(len);
        phase_items += len;
        if ($urandom_range(19) == 0) wait_results();
      end
    end

    // ---- drain and verdict ----
    wait_quiet();
    idle_pct  = 0;
    stall_pct = 0;
    $display("Sent %0d samples in %0d runs, one of them past the %0d-sample limit;",
             sample_total, run_total, MAX_SAMPLES);
    $display("checked %0d bands over factors 0, 1, 255 and random under four idle mixes.",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d bands never arrived", errors, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== mean_stddev_band_limits.f =====
design/msbl_pkg.sv
design/msbl_ctrl.sv
design/msbl_datapath.sv
design/mean_stddev_band_limits.sv
tb/sv/band_limits_checker.sv
tb/sv/testbench.sv
